// File: src/assert_macros.svh
// Shared assertion macros for the overlay checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off while rst is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, held off while rst is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// File: src/bbo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bbo_pkg;

   localparam int MAX_BOXES_DEFAULT = 16;

   localparam logic [1:0] CMD_PIXEL = 2'd0;
   localparam logic [1:0] CMD_ADD   = 2'd1;
   localparam logic [1:0] CMD_CLEAR = 2'd2;

   localparam logic CSR_FRAME_WIDTH  = 1'b0;
   localparam logic CSR_FRAME_HEIGHT = 1'b1;

   localparam logic [12:0] FRAME_WIDTH_RESET  = 13'd640;
   localparam logic [12:0] FRAME_HEIGHT_RESET = 13'd480;

   localparam logic signed [15:0] LINE_THICKNESS = 16'sd2;

   typedef struct packed {
      logic signed [13:0] left;
      logic signed [13:0] top;
      logic signed [13:0] right;
      logic signed [13:0] bottom;
      logic [2:0]         color;
   } box_type;

   function automatic logic signed [15:0] sx14(input logic [13:0] v);
      return signed'({{2{v[13]}}, v});
   endfunction

   // class mod 6 via reciprocal multiply; exact for all 8-bit inputs
   function automatic logic [2:0] color_index(input logic [7:0] c);
      logic [15:0] prod;
      logic [5:0]  q;
      logic [7:0]  rem;
      prod = 16'(c) * 16'd171;
      q    = prod[15:10];
      rem  = c - 8'({2'b00, q} * 8'd6);
      return rem[2:0];
   endfunction

   // packed as {red, green, blue}
   function automatic logic [23:0] palette(input logic [2:0] idx);
      logic [23:0] rgb;
      case (idx)
         3'd0: rgb = {8'd0,   8'd255, 8'd0};
         3'd1: rgb = {8'd255, 8'd0,   8'd0};
         3'd2: rgb = {8'd0,   8'd0,   8'd255};
         3'd3: rgb = {8'd255, 8'd255, 8'd0};
         3'd4: rgb = {8'd255, 8'd0,   8'd255};
         3'd5: rgb = {8'd0,   8'd255, 8'd255};
         default: rgb = 24'd0;
      endcase
      return rgb;
   endfunction

   function automatic logic on_outline(input logic signed [15:0] x,
                                       input logic signed [15:0] y,
                                       input box_type b);
      logic signed [15:0] l, t, r, bt;
      logic in_cols, in_rows, row_hit, col_hit;
      l  = sx14(b.left);
      t  = sx14(b.top);
      r  = sx14(b.right);
      bt = sx14(b.bottom);
      in_cols = (x >= l) && (x <= r);
      in_rows = (y >= t) && (y <= bt);
      row_hit = ((y >= t) && (y < t + LINE_THICKNESS)) ||
                ((y <= bt) && (y > bt - LINE_THICKNESS));
      col_hit = ((x >= l) && (x < l + LINE_THICKNESS)) ||
                ((x <= r) && (x > r - LINE_THICKNESS));
      return (row_hit && in_cols) || (col_hit && in_rows);
   endfunction

endpackage

`default_nettype wire

// File: src/bounding_box_overlay.sv
`timescale 1ns / 1ps
`default_nettype none
// Path: a req transaction passes the input register, then the result register, to rsp_tvalid.
// Throughput: one transaction per clock unless stalled; all box lanes compare in parallel.
// Backpressure: a stalled result holds; the input register still fills behind it.
// Reset (synchronous, active high): empties the box table count, sets frame to 640x480,
// drops any transaction in flight. Box entries are not cleared; unused ones are never read.
module bounding_box_overlay #(
   parameter int MAX_BOXES = bbo_pkg::MAX_BOXES_DEFAULT
) (
   input  wire logic         clock,
   input  wire logic         reset,
   // req_tdata, lowest bit up: pixel_x[11:0], pixel_y[23:12], in_blue[31:24],
   // in_green[39:32], in_red[47:40], box_left[61:48], box_top[75:62],
   // box_right[89:76], box_bottom[103:90], box_class[111:104]
   input  wire logic [111:0] req_tdata,
   // req_tuser: command[1:0]
   input  wire logic [1:0]   req_tuser,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // rsp_tdata, lowest bit up: out_blue[7:0], out_green[15:8], out_red[23:16]
   output logic [23:0]       rsp_tdata,
   // rsp_tuser, lowest bit up: on_box[0], status[1]
   output logic [1:0]        rsp_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   input  wire logic         csr_we,
   input  wire logic         csr_index,
   input  wire logic [12:0]  csr_wdata
);

   localparam int CNT_W = $clog2(MAX_BOXES + 1);

   // configuration registers
   logic [12:0] width_ff, height_ff;

   // input register
   logic         s1_valid_ff, s1_valid_in;
   logic [111:0] s1_data_ff;
   logic [1:0]   s1_cmd_ff;

   // result register
   logic        out_valid_ff, out_valid_in;
   logic [23:0] out_data_ff, out_data_in;
   logic [1:0]  out_user_ff, out_user_in;

   // box table: one lane per entry, count marks the live ones
   logic [CNT_W-1:0]  count_ff, count_in;
   bbo_pkg::box_type  table_ff [MAX_BOXES];
   bbo_pkg::box_type  new_box;
   logic [MAX_BOXES-1:0] lane_hit;

   logic advance;
   logic table_full;
   logic table_we;

   // fields of the held transaction
   logic [11:0] px, py;
   logic [23:0] pix_rgb;
   logic [13:0] b_left, b_top, b_right, b_bottom;
   logic [7:0]  b_class;
   logic signed [15:0] x_s, y_s, wmax, hmax;
   logic in_frame;
   logic any_hit;
   logic [2:0] hit_color;

   assign px       = s1_data_ff[11:0];
   assign py       = s1_data_ff[23:12];
   assign pix_rgb  = s1_data_ff[47:24];
   assign b_left   = s1_data_ff[61:48];
   assign b_top    = s1_data_ff[75:62];
   assign b_right  = s1_data_ff[89:76];
   assign b_bottom = s1_data_ff[103:90];
   assign b_class  = s1_data_ff[111:104];

   // Advance the held transaction whenever the result slot is free or being drained.
   assign advance    = s1_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || advance;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_tvalid && req_tready) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_tvalid && req_tready) begin
         s1_data_ff <= req_tdata;
         s1_cmd_ff  <= req_tuser;
      end
   end

   // Configuration writes: take the register at the index, ignore anything else.
   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= bbo_pkg::FRAME_WIDTH_RESET;
         height_ff <= bbo_pkg::FRAME_HEIGHT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            bbo_pkg::CSR_FRAME_WIDTH:  width_ff  <= csr_wdata;
            bbo_pkg::CSR_FRAME_HEIGHT: height_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Clamp the new box to the frame: left/top at least 0, right/bottom at most size-1.
   assign wmax = signed'({3'b000, width_ff}) - 16'sd1;
   assign hmax = signed'({3'b000, height_ff}) - 16'sd1;

   always_comb begin
      new_box.left   = b_left[13] ? 14'sd0 : b_left;
      new_box.top    = b_top[13]  ? 14'sd0 : b_top;
      new_box.right  = (bbo_pkg::sx14(b_right) > wmax)  ? wmax[13:0] : b_right;
      new_box.bottom = (bbo_pkg::sx14(b_bottom) > hmax) ? hmax[13:0] : b_bottom;
      new_box.color  = bbo_pkg::color_index(b_class);
   end

   assign table_full = (count_ff >= CNT_W'(MAX_BOXES));
   assign table_we   = advance && (s1_cmd_ff == bbo_pkg::CMD_ADD) && !table_full;

   always_comb begin
      count_in = count_ff;
      if (advance && (s1_cmd_ff == bbo_pkg::CMD_CLEAR)) begin
         count_in = '0;
      end else if (table_we) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   assign x_s = signed'({4'b0000, px});
   assign y_s = signed'({4'b0000, py});

   // One lane per entry: store on its turn, compare against the current pixel.
   for (genvar i = 0; i < MAX_BOXES; i++) begin : g_lane
      always_ff @(posedge clock) begin
         if (table_we && (count_ff == CNT_W'(i))) begin
            table_ff[i] <= new_box;
         end
      end
      assign lane_hit[i] = (count_ff > CNT_W'(i)) &&
                           bbo_pkg::on_outline(x_s, y_s, table_ff[i]);
   end

   // Newest box wins: later lanes override earlier ones.
   always_comb begin
      hit_color = 3'd0;
      for (int i = 0; i < MAX_BOXES; i++) begin
         if (lane_hit[i]) begin
            hit_color = table_ff[i].color;
         end
      end
   end

   assign any_hit  = |lane_hit;
   assign in_frame = ({1'b0, px} < width_ff) && ({1'b0, py} < height_ff);

   always_comb begin
      out_data_in = 24'd0;
      out_user_in = 2'b00;
      case (s1_cmd_ff)
         bbo_pkg::CMD_PIXEL: begin
            if (in_frame && any_hit) begin
               out_data_in = bbo_pkg::palette(hit_color);
               out_user_in = 2'b01;
            end else begin
               out_data_in = pix_rgb;
            end
         end
         bbo_pkg::CMD_ADD: begin
            out_user_in = {table_full, 1'b0};
         end
         default: ;
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
      if (advance) begin
         out_data_ff <= out_data_in;
         out_user_ff <= out_user_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;
   assign rsp_tuser  = out_user_ff;

endmodule

`default_nettype wire

// File: src/bbo_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module bbo_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic [23:0] rsp_tdata,
   input wire logic [1:0]  rsp_tuser,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready
);

   // every byte of a palette color is either fully off or fully on
   logic hit_bytes_ok;

   assign hit_bytes_ok = (rsp_tdata[7:0] == 8'd0 || rsp_tdata[7:0] == 8'd255) &&
                         (rsp_tdata[15:8] == 8'd0 || rsp_tdata[15:8] == 8'd255) &&
                         (rsp_tdata[23:16] == 8'd0 || rsp_tdata[23:16] == 8'd255);

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   `ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid)
   `ASSERT_IMPLIES(a_hit_ok, clock, reset, rsp_tvalid && rsp_tuser[0], !rsp_tuser[1])
   `ASSERT_IMPLIES(a_drop_zero, clock, reset, rsp_tvalid && rsp_tuser[1], rsp_tdata == 24'd0)
   `ASSERT_IMPLIES(a_hit_color, clock, reset, rsp_tvalid && rsp_tuser[0], hit_bytes_ok)

endmodule

bind bounding_box_overlay bbo_checker u_bbo_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready)
);

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;

   // command 3 has no meaning in the block: it must change nothing
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam int TABLE_DEPTH = 16;
   localparam int COLOR_COUNT = 6;
   localparam int PIXEL_MAX = 4095;
   localparam int ITEMS_PER_FRAME = 200;
   localparam int CYCLE_LIMIT = 800000;

   // Request fields, first declared member lands in the top bits of req_tdata.
   typedef struct packed {
      logic [7:0]  box_class;
      logic [13:0] box_bottom;
      logic [13:0] box_right;
      logic [13:0] box_top;
      logic [13:0] box_left;
      logic [7:0]  in_red;
      logic [7:0]  in_green;
      logic [7:0]  in_blue;
      logic [11:0] pixel_y;
      logic [11:0] pixel_x;
   } overlay_request_type;

   typedef struct {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
      logic       on_box;
      logic       status;
   } overlay_result_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic [111:0] req_tdata = '0;
   logic [1:0]   req_tuser = bbo_pkg::CMD_PIXEL;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [23:0]  rsp_tdata;
   logic [1:0]   rsp_tuser;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic         csr_we = 1'b0;
   logic         csr_index = bbo_pkg::CSR_FRAME_WIDTH;
   logic [12:0]  csr_wdata = '0;

   // Shadow of the block: box table, fill count and frame size.
   int drawn_left [TABLE_DEPTH];
   int drawn_top [TABLE_DEPTH];
   int drawn_right [TABLE_DEPTH];
   int drawn_bottom [TABLE_DEPTH];
   int drawn_color [TABLE_DEPTH];
   int stored_boxes = 0;
   int frame_w = bbo_pkg::FRAME_WIDTH_RESET;
   int frame_h = bbo_pkg::FRAME_HEIGHT_RESET;

   // Overlay results still owed by the block, oldest first.
   overlay_result_type expected_overlay[$];
   overlay_result_type oldest;

   int  fail_count = 0;
   int  cycle_count = 0;
   int  rsp_hold = 0;
   int  rsp_stall = 0;
   bit  idle_gaps = 1'b1;

   bounding_box_overlay #(.MAX_BOXES(TABLE_DEPTH)) uut (.*);

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------

   // Palette entry packed as {blue, green, red}.
   function automatic logic [23:0] box_color(input int idx);
      case (idx)
         0: return {8'd0,   8'd255, 8'd0};
         1: return {8'd0,   8'd0,   8'd255};
         2: return {8'd255, 8'd0,   8'd0};
         3: return {8'd0,   8'd255, 8'd255};
         4: return {8'd255, 8'd0,   8'd255};
         default: return {8'd255, 8'd255, 8'd0};
      endcase
   endfunction

   // Advance the shadow table by one transaction and return the overlay result.
   function automatic overlay_result_type apply_overlay(input logic [1:0] cmd,
                                                        input overlay_request_type item);
      overlay_result_type res;
      int x, y, l, t, r, b;
      bit row_hit, col_hit;
      logic [23:0] bgr;
      res = '{default: '0};
      case (cmd)
         bbo_pkg::CMD_PIXEL: begin
            res.blue  = item.in_blue;
            res.green = item.in_green;
            res.red   = item.in_red;
            x = item.pixel_x;
            y = item.pixel_y;
            // pixels outside the frame pass untouched; otherwise scan newest box first
            if (x < frame_w && y < frame_h) begin
               for (int i = stored_boxes - 1; i >= 0; i--) begin
                  l = drawn_left[i];
                  t = drawn_top[i];
                  r = drawn_right[i];
                  b = drawn_bottom[i];
                  row_hit = ((y >= t && y < t + bbo_pkg::LINE_THICKNESS) ||
                             (y <= b && y > b - bbo_pkg::LINE_THICKNESS)) &&
                            x >= l && x <= r;
                  col_hit = ((x >= l && x < l + bbo_pkg::LINE_THICKNESS) ||
                             (x <= r && x > r - bbo_pkg::LINE_THICKNESS)) &&
                            y >= t && y <= b;
                  if (row_hit || col_hit) begin
                     bgr = box_color(drawn_color[i]);
                     res.blue   = bgr[23:16];
                     res.green  = bgr[15:8];
                     res.red    = bgr[7:0];
                     res.on_box = 1'b1;
                     break;
                  end
               end
            end
         end
         bbo_pkg::CMD_ADD: begin
            if (stored_boxes >= TABLE_DEPTH) begin
               res.status = 1'b1;
            end else begin
               // clamp to the frame; an inverted box is kept as it is
               l = int'($signed(item.box_left));
               t = int'($signed(item.box_top));
               r = int'($signed(item.box_right));
               b = int'($signed(item.box_bottom));
               drawn_left[stored_boxes]   = (l < 0) ? 0 : l;
               drawn_top[stored_boxes]    = (t < 0) ? 0 : t;
               drawn_right[stored_boxes]  = (r > frame_w - 1) ? frame_w - 1 : r;
               drawn_bottom[stored_boxes] = (b > frame_h - 1) ? frame_h - 1 : b;
               drawn_color[stored_boxes]  = int'(item.box_class) % COLOR_COUNT;
               stored_boxes++;
            end
         end
         bbo_pkg::CMD_CLEAR: begin
            stored_boxes = 0;
         end
         default: begin
         end
      endcase
      return res;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   // Idle length for either side: mostly none or short, now and then long.
   function automatic int pick_gap();
      int roll;
      if (!idle_gaps) return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60) return 0;
      if (roll < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Fully random request; callers overwrite the fields that matter.
   function automatic overlay_request_type random_request();
      logic [127:0] noise;
      noise = {$urandom(), $urandom(), $urandom(), $urandom()};
      return noise[111:0];
   endfunction

   // Coordinate on or right next to an outline edge between lo and hi, or anywhere between.
   function automatic int near_edge(input int lo, input int hi);
      case ($urandom_range(0, 6))
         0: return lo;
         1: return lo + 1;
         2: return hi - 1;
         3: return hi;
         4: return lo - 1;
         5: return hi + 1;
         default: return lo + $urandom_range(0, (hi > lo) ? hi - lo : 0);
      endcase
   endfunction

   // Mostly pixels aimed at stored outlines, with box adds, clears and noise.
   task automatic next_random_item(output logic [1:0] cmd,
                                   output overlay_request_type item);
      int pick, span_x, span_y, k, x, y, l, t;
      item = random_request();
      span_x = (frame_w > PIXEL_MAX) ? PIXEL_MAX : frame_w;
      span_y = (frame_h > PIXEL_MAX) ? PIXEL_MAX : frame_h;
      pick = $urandom_range(0, 99);
      if (pick < 2) begin
         cmd = bbo_pkg::CMD_CLEAR;
      end else if (pick < 3) begin
         cmd = CMD_UNUSED;
      end else if (pick < 15) begin
         cmd = bbo_pkg::CMD_ADD;
         // one add in ten keeps its fully random edges
         if ($urandom_range(0, 9) != 0) begin
            l = $urandom_range(0, span_x) - 3;
            t = $urandom_range(0, span_y) - 3;
            item.box_left = 14'(l);
            item.box_top  = 14'(t);
            if ($urandom_range(0, 7) == 0) begin
               item.box_right  = 14'(l + $urandom_range(0, span_x));
               item.box_bottom = 14'(t + $urandom_range(0, span_y));
            end else begin
               item.box_right  = 14'(l + $urandom_range(0, 40) - 2);
               item.box_bottom = 14'(t + $urandom_range(0, 40) - 2);
            end
         end
      end else begin
         cmd = bbo_pkg::CMD_PIXEL;
         pick = $urandom_range(0, 9);
         if (pick < 7 && stored_boxes > 0) begin
            k = $urandom_range(0, stored_boxes - 1);
            x = near_edge(drawn_left[k], drawn_right[k]);
            y = near_edge(drawn_top[k], drawn_bottom[k]);
         end else if (pick < 9) begin
            x = $urandom_range(0, span_x + 2);
            y = $urandom_range(0, span_y + 2);
         end else begin
            x = item.pixel_x;
            y = item.pixel_y;
         end
         x = (x < 0) ? 0 : (x > PIXEL_MAX) ? PIXEL_MAX : x;
         y = (y < 0) ? 0 : (y > PIXEL_MAX) ? PIXEL_MAX : y;
         item.pixel_x = 12'(x);
         item.pixel_y = 12'(y);
      end
   endtask

   // Offer one transaction, hold it until accepted, then log its expected result.
   task automatic send_item(input logic [1:0] cmd, input overlay_request_type item);
      int gap;
      gap = pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tuser  <= cmd;
      req_tdata  <= item;
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_overlay.push_back(apply_overlay(cmd, item));
   endtask

   // Drop valid right after the last acceptance and drain every owed result.
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_overlay.size() != 0) @(posedge clock);
      // let the two pipeline stages settle before touching registers
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic index, input int value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value[12:0];
      @(negedge clock);
      csr_we <= 1'b0;
      if (index == bbo_pkg::CSR_FRAME_WIDTH) frame_w = value;
      else frame_h = value;
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // With no boxes stored, the corner pixels come back unchanged.
   task automatic test_pass_through();
      overlay_request_type item;
      item = random_request();
      item.pixel_x  = '0;
      item.pixel_y  = '0;
      item.in_blue  = '0;
      item.in_green = '0;
      item.in_red   = '0;
      send_item(bbo_pkg::CMD_PIXEL, item);
      item.pixel_x  = '1;
      item.pixel_y  = '1;
      item.in_blue  = '1;
      item.in_green = '1;
      item.in_red   = '1;
      send_item(bbo_pkg::CMD_PIXEL, item);
   endtask

   // Fill the table, overflow it, probe outlines, then clear.
   task automatic test_box_table();
      overlay_request_type item;
      int probe_x [5] = '{0, 639, 20, 22, 4095};
      int probe_y [5] = '{0, 479, 20, 22, 0};
      // extreme edges clamp to the whole default frame
      item = random_request();
      item.box_left   = 14'h2000;
      item.box_top    = 14'h2000;
      item.box_right  = 14'h1FFF;
      item.box_bottom = 14'h1FFF;
      item.box_class  = 8'd0;
      send_item(bbo_pkg::CMD_ADD, item);
      // small boxes along the diagonal, one inverted, classes wrap past six
      for (int i = 1; i < TABLE_DEPTH; i++) begin
         item = random_request();
         item.box_left   = 14'(20 * i);
         item.box_top    = 14'(20 * i);
         item.box_right  = (i == 7) ? 14'(20 * i - 1) : 14'(20 * i + 4);
         item.box_bottom = 14'(20 * i + 4);
         item.box_class  = (i == TABLE_DEPTH - 1) ? 8'd255 : 8'(i);
         send_item(bbo_pkg::CMD_ADD, item);
      end
      // table is full: this add is dropped and flagged
      send_item(bbo_pkg::CMD_ADD, random_request());
      // frame corners, a box corner, a box interior, a pixel off the frame
      for (int i = 0; i < 5; i++) begin
         item = random_request();
         item.pixel_x = 12'(probe_x[i]);
         item.pixel_y = 12'(probe_y[i]);
         send_item(bbo_pkg::CMD_PIXEL, item);
      end
      send_item(CMD_UNUSED, random_request());
      send_item(bbo_pkg::CMD_CLEAR, random_request());
      item = random_request();
      item.pixel_x = '0;
      item.pixel_y = '0;
      send_item(bbo_pkg::CMD_PIXEL, item);
   endtask

   // Random traffic under a series of frame sizes, including zero and the maximum.
   task automatic test_random_frames();
      int widths [8]  = '{64, 640, 4096, 1, 0, 8191, 200, 33};
      int heights [8] = '{48, 480, 4096, 1, 40, 8191, 0, 4096};
      logic [1:0] cmd;
      overlay_request_type item;
      for (int f = 0; f < 8; f++) begin
         wait_idle();
         write_register(bbo_pkg::CSR_FRAME_WIDTH, widths[f]);
         write_register(bbo_pkg::CSR_FRAME_HEIGHT, heights[f]);
         for (int n = 0; n < ITEMS_PER_FRAME; n++) begin
            // switch idling off for some stretches
            if (n % 50 == 0) idle_gaps = ($urandom_range(0, 3) != 0);
            next_random_item(cmd, item);
            send_item(cmd, item);
         end
      end
      idle_gaps = 1'b1;
   endtask

   // Hold off the result side long enough for the block to stall its input.
   task automatic test_backpressure();
      logic [1:0] cmd;
      overlay_request_type item;
      wait_idle();
      write_register(bbo_pkg::CSR_FRAME_WIDTH, 64);
      write_register(bbo_pkg::CSR_FRAME_HEIGHT, 64);
      idle_gaps = 1'b0;
      rsp_hold = 250;
      for (int n = 0; n < 40; n++) begin
         next_random_item(cmd, item);
         send_item(cmd, item);
      end
      idle_gaps = 1'b1;
   endtask

   // ---------------------------------------------------------------------------
   // Result side
   // ---------------------------------------------------------------------------

   // Drive rsp_tready: a counted long hold when asked, otherwise random stalls.
   always @(negedge clock) begin
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold = rsp_hold - 1;
      end else if (rsp_stall > 0) begin
         rsp_tready <= 1'b0;
         rsp_stall = rsp_stall - 1;
      end else begin
         rsp_tready <= 1'b1;
         rsp_stall = pick_gap();
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // Compare each accepted result against the oldest owed one.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_overlay.size() == 0) begin
            $error("result transaction with no expectation pending");
            fail_count++;
         end else begin
            oldest = expected_overlay.pop_front();
            check_field("out_blue", oldest.blue, rsp_tdata[7:0]);
            check_field("out_green", oldest.green, rsp_tdata[15:8]);
            check_field("out_red", oldest.red, rsp_tdata[23:16]);
            check_field("on_box", oldest.on_box, rsp_tuser[0]);
            check_field("status", oldest.status, rsp_tuser[1]);
         end
      end
   end

   // Watchdog: a hung handshake ends the run as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      test_pass_through();
      test_box_table();
      test_random_frames();
      test_backpressure();
      wait_idle();
      if (fail_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
